FILE: hdl/fdht_pkg.sv
// ----------------------------------------------------------------------------
// Hex float text formatter package
// Shared types, slot codes, character codes and helpers for the %a formatter.
// ----------------------------------------------------------------------------
package fdht_pkg;

  // Default run length counter width.
  localparam int unsigned CountWidthDefault = 16;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgIdxLegacy    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxStdRound  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgIdxRoundMode = 2'd2;

  // Rounding modes used when standard rounding is on.
  typedef enum logic [1:0] {
    RndNearestEven = 2'd0,
    RndDown        = 2'd1,
    RndUp          = 2'd2,
    RndZero        = 2'd3
  } round_mode_e;

  // Sign styles for non-negative values.
  localparam logic [1:0] SignPlus  = 2'd1;
  localparam logic [1:0] SignSpace = 2'd2;

  // ASCII codes.
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChPlus   = 8'h2b;
  localparam logic [7:0] ChMinus  = 8'h2d;
  localparam logic [7:0] ChPoint  = 8'h2e;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChLowA   = 8'h61;
  localparam logic [7:0] ChUpA    = 8'h41;
  localparam logic [7:0] ChLowX   = 8'h78;
  localparam logic [7:0] ChUpX    = 8'h58;
  localparam logic [7:0] ChLowP   = 8'h70;
  localparam logic [7:0] ChUpP    = 8'h50;

  // Every possible run of one value has a fixed slot; a mask marks the ones present.
  localparam int unsigned NumSlots = 30;
  typedef logic [4:0] slot_t;
  localparam slot_t SlotPadLead    = 5'd0;
  localparam slot_t SlotSign       = 5'd1;
  localparam slot_t SlotPre0       = 5'd2;
  localparam slot_t SlotPreX       = 5'd3;
  localparam slot_t SlotZeroPad    = 5'd4;
  localparam slot_t SlotBody0      = 5'd5;
  localparam slot_t SlotBodyX      = 5'd6;
  localparam slot_t SlotLead       = 5'd7;
  localparam slot_t SlotPoint      = 5'd8;
  localparam slot_t SlotFrac0      = 5'd9;
  localparam slot_t SlotFracLast   = 5'd21;
  localparam slot_t SlotZeroRun    = 5'd22;
  localparam slot_t SlotExpMark    = 5'd23;
  localparam slot_t SlotExpSign    = 5'd24;
  localparam slot_t SlotExpDig0    = 5'd25;
  localparam slot_t SlotExpDigLast = 5'd28;
  localparam slot_t SlotPadTrail   = 5'd29;

  localparam int unsigned MaxFracDigits = 13;

  // Everything the run sequencer needs to spell out one value.
  typedef struct packed {
    logic [51:0]      frac;       // rounded fraction nibbles, most significant first
    logic [3:0]       lead;       // digit before the point
    logic [3:0][3:0]  exp_dig;    // exponent digits, entry 0 printed first
    logic             exp_neg;
    logic [7:0]       sign_char;
    logic             upper;
    logic [15:0]      pad_len;
    logic [15:0]      zero_len;
    logic [16:0]      total;
  } fdht_desc_t;

  // Hex digit to ASCII.
  function automatic logic [7:0] hex_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = ChZero + {4'd0, d};
    end else begin
      c = (upper ? ChUpA : ChLowA) + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

FILE: hdl/format_double_hex_text.sv
// ----------------------------------------------------------------------------
// Hex float text formatter (printf %a) for binary64
// Turns one binary64 value and its format settings into character runs.
// ----------------------------------------------------------------------------
// Each accepted value comes out as a sequence of character runs, one output
// word per cycle while the output is not stalled, 6 to 26 runs per value. The
// value passes through the input register and the sequencer's descriptor
// register before its first run goes into the output register. The sequencer
// loads the next value as it sends the last run of the previous one, so the
// output channel sets the sustained rate. A new value is taken while runs of
// the previous one are still being sent. Configuration registers must be written
// only while the block has no value in flight; the block does not enforce this.
module format_double_hex_text #(
  parameter int unsigned COUNT_WIDTH = fdht_pkg::CountWidthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fdht_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [1:0]                    cfg_data_i,
  // Input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [63:0]                   value_bits_i,
  input  logic [15:0]                   field_width_i,
  input  logic signed [16:0]            precision_i,
  input  logic                          left_justify_i,
  input  logic                          zero_pad_i,
  input  logic                          alternate_form_i,
  input  logic [1:0]                    sign_style_i,
  input  logic                          upper_case_i,
  // Output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    out_char_o,
  output logic [15:0]                   run_length_o,
  output logic                          last_run_o,
  output logic [16:0]                   total_chars_o
);
  import fdht_pkg::*;

  logic        legacy_q;
  logic        std_round_q;
  round_mode_e round_mode_q;

  logic              in_valid_q, in_valid_d;
  logic              in_acc;
  logic [63:0]       value_bits_q;
  logic [15:0]       field_width_q;
  logic signed [16:0] precision_q;
  logic              left_justify_q;
  logic              zero_pad_q;
  logic              alternate_form_q;
  logic [1:0]        sign_style_q;
  logic              upper_case_q;

  logic                desc_ready;
  logic [NumSlots-1:0] mask;
  fdht_desc_t          desc;

  // Configuration registers, always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      legacy_q     <= 1'b0;
      std_round_q  <= 1'b0;
      round_mode_q <= RndNearestEven;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgIdxLegacy:    legacy_q     <= cfg_data_i[0];
        CfgIdxStdRound:  std_round_q  <= cfg_data_i[0];
        CfgIdxRoundMode: round_mode_q <= round_mode_e'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Input register: holds a value until the sequencer takes it.
  always_comb begin
    in_stall_o = in_valid_q && !desc_ready;
    in_acc     = in_valid_i && !in_stall_o;
    if (in_acc) begin
      in_valid_d = 1'b1;
    end else if (desc_ready) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      value_bits_q     <= value_bits_i;
      field_width_q    <= field_width_i;
      precision_q      <= precision_i;
      left_justify_q   <= left_justify_i;
      zero_pad_q       <= zero_pad_i;
      alternate_form_q <= alternate_form_i;
      sign_style_q     <= sign_style_i;
      upper_case_q     <= upper_case_i;
    end
  end

  // Decode, round and size the value.
  fdht_prep #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_prep (
    .legacy_i         (legacy_q),
    .std_round_i      (std_round_q),
    .round_mode_i     (round_mode_q),
    .value_bits_i     (value_bits_q),
    .field_width_i    (field_width_q),
    .precision_i      (precision_q),
    .left_justify_i   (left_justify_q),
    .zero_pad_i       (zero_pad_q),
    .alternate_form_i (alternate_form_q),
    .sign_style_i     (sign_style_q),
    .upper_case_i     (upper_case_q),
    .mask_o           (mask),
    .desc_o           (desc)
  );

  // Send the runs.
  fdht_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .desc_valid_i  (in_valid_q),
    .desc_ready_o  (desc_ready),
    .mask_i        (mask),
    .desc_i        (desc),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_char_o    (out_char_o),
    .run_length_o  (run_length_o),
    .last_run_o    (last_run_o),
    .total_chars_o (total_chars_o)
  );

endmodule

FILE: hdl/fdht_prep.sv
// ----------------------------------------------------------------------------
// Hex float text formatter: value decode
// Rounds the significand, splits the exponent into decimal digits and works
// out the run lengths and which runs are present for one value.
// ----------------------------------------------------------------------------
module fdht_prep #(
  parameter int unsigned COUNT_WIDTH = fdht_pkg::CountWidthDefault
) (
  input  logic                     legacy_i,
  input  logic                     std_round_i,
  input  fdht_pkg::round_mode_e    round_mode_i,
  input  logic [63:0]              value_bits_i,
  input  logic [15:0]              field_width_i,
  input  logic signed [16:0]       precision_i,
  input  logic                     left_justify_i,
  input  logic                     zero_pad_i,
  input  logic                     alternate_form_i,
  input  logic [1:0]               sign_style_i,
  input  logic                     upper_case_i,
  output logic [fdht_pkg::NumSlots-1:0] mask_o,
  output fdht_pkg::fdht_desc_t     desc_o
);
  import fdht_pkg::*;

  localparam int unsigned RunCapInt =
      (COUNT_WIDTH >= 16) ? 32'd65535 : ((32'd1 << COUNT_WIDTH) - 32'd1);
  localparam logic [15:0] RunCap = 16'(RunCapInt);

  logic        neg;
  logic [10:0] bexp;
  logic [51:0] frac;
  logic [55:0] mant;
  logic [15:0] prec;
  logic [3:0]  kept;
  logic [15:0] zeroes;
  logic        point;
  logic [3:0]  gidx;
  logic [3:0]  lidx;
  logic [3:0]  guard;
  logic [51:0] low_mask;
  logic        sticky;
  logic        lsb_bit;
  logic        up;
  logic [55:0] rounded;
  logic [10:0] mag;
  logic        exp_neg;
  logic        thou;
  logic [9:0]  rem_k;
  logic [15:0] hu_prod;
  logic [17:0] te_prod;
  logic [6:0]  q10;
  logic [3:0]  d_hu;
  logic [3:0]  d_te;
  logic [3:0]  d_on;
  logic [2:0]  ne;
  logic [3:0][3:0] exp_dig;
  logic        sign_on;
  logic [7:0]  sign_char;
  logic [5:0]  fixed_len;
  logic [16:0] total;
  logic [16:0] width_ext;
  logic [15:0] padding;

  // Significand, precision and digits kept.
  always_comb begin
    neg  = value_bits_i[63];
    bexp = value_bits_i[62:52];
    frac = value_bits_i[51:0];
    mant = {3'd0, (bexp != 11'd0), frac};
    if (precision_i[16]) begin
      prec = legacy_i ? 16'd6 : 16'(MaxFracDigits);
    end else begin
      prec = precision_i[15:0];
    end
    if (legacy_i && prec > 16'd512) begin
      prec = 16'd512;
    end
    kept   = (prec < 16'(MaxFracDigits)) ? prec[3:0] : 4'(MaxFracDigits);
    zeroes = prec - {12'd0, kept};
    point  = (prec != 16'd0) || alternate_form_i;
  end

  // Rounding on the nibbles below the last kept digit.
  always_comb begin
    gidx     = (kept < 4'(MaxFracDigits)) ? 4'd12 - kept : 4'd0;
    lidx     = gidx + 4'd1;
    guard    = mant[{gidx, 2'b00} +: 4];
    low_mask = ~({52{1'b1}} << {gidx, 2'b00});
    sticky   = (guard[2:0] != 3'd0) || ((frac & low_mask) != 52'd0);
    lsb_bit  = mant[{lidx, 2'b00}];
    up       = 1'b0;
    if (kept < 4'(MaxFracDigits)) begin
      if (legacy_i) begin
        up = guard > 4'd8;
      end else if (!std_round_i) begin
        up = guard[3];
      end else begin
        unique case (round_mode_i)
          RndNearestEven: up = guard[3] && (sticky || lsb_bit);
          RndDown:        up = (guard != 4'd0) && neg;
          RndUp:          up = (guard != 4'd0) && !neg;
          RndZero:        up = 1'b0;
          default:        up = 1'b0;
        endcase
      end
    end
    rounded = mant + (up ? (56'd1 << {lidx, 2'b00}) : 56'd0);
  end

  // Exponent magnitude and its decimal digits.
  always_comb begin
    if (bexp == 11'd0) begin
      exp_neg = (frac != 52'd0);
      mag     = exp_neg ? 11'd1022 : 11'd0;
    end else if (bexp >= 11'd1023) begin
      exp_neg = 1'b0;
      mag     = bexp - 11'd1023;
    end else begin
      exp_neg = 1'b1;
      mag     = 11'd1023 - bexp;
    end
    thou    = mag >= 11'd1000;
    rem_k   = thou ? 10'(mag - 11'd1000) : mag[9:0];
    hu_prod = {6'd0, rem_k} * 16'd41;
    d_hu    = hu_prod[15:12];
    te_prod = {8'd0, rem_k} * 18'd205;
    q10     = te_prod[17:11];
    d_te    = 4'(q10 - {3'd0, d_hu} * 7'd10);
    d_on    = 4'(rem_k - {3'd0, q10} * 10'd10);
    exp_dig = '0;
    if (thou) begin
      ne = 3'd4;
      exp_dig[0] = 4'd1;
      exp_dig[1] = d_hu;
      exp_dig[2] = d_te;
      exp_dig[3] = d_on;
    end else if (mag >= 11'd100) begin
      ne = 3'd3;
      exp_dig[0] = d_hu;
      exp_dig[1] = d_te;
      exp_dig[2] = d_on;
    end else if (mag >= 11'd10) begin
      ne = 3'd2;
      exp_dig[0] = d_te;
      exp_dig[1] = d_on;
    end else begin
      ne = 3'd1;
      exp_dig[0] = d_on;
    end
  end

  // Sign, total length and padding.
  always_comb begin
    sign_on   = neg || (sign_style_i == SignPlus) || (sign_style_i == SignSpace);
    sign_char = neg ? ChMinus : ((sign_style_i == SignPlus) ? ChPlus : ChSpace);
    fixed_len = 6'd5 + {5'd0, sign_on} + {5'd0, point} + {2'd0, kept} + {3'd0, ne};
    total     = {1'b0, zeroes} + {11'd0, fixed_len};
    width_ext = {1'b0, field_width_i};
    padding   = (width_ext > total) ? 16'(width_ext - total) : 16'd0;
  end

  // Runs that this value produces.
  always_comb begin
    mask_o = '0;
    mask_o[SlotPadLead]  = !left_justify_i && !zero_pad_i && (padding != 16'd0);
    mask_o[SlotSign]     = sign_on;
    mask_o[SlotPre0]     = !legacy_i;
    mask_o[SlotPreX]     = !legacy_i;
    mask_o[SlotZeroPad]  = !left_justify_i && zero_pad_i && (padding != 16'd0);
    mask_o[SlotBody0]    = legacy_i;
    mask_o[SlotBodyX]    = legacy_i;
    mask_o[SlotLead]     = 1'b1;
    mask_o[SlotPoint]    = point;
    for (int j = 0; j < int'(MaxFracDigits); j++) begin
      mask_o[int'(SlotFrac0) + j] = (4'(j) < kept);
    end
    mask_o[SlotZeroRun]  = (zeroes != 16'd0);
    mask_o[SlotExpMark]  = 1'b1;
    mask_o[SlotExpSign]  = 1'b1;
    for (int j = 0; j < 4; j++) begin
      mask_o[int'(SlotExpDig0) + j] = (3'(j) < ne);
    end
    mask_o[SlotPadTrail] = left_justify_i && (padding != 16'd0);
  end

  // Descriptor handed to the run sequencer.
  always_comb begin
    desc_o.frac      = rounded[51:0];
    desc_o.lead      = rounded[55:52];
    desc_o.exp_dig   = exp_dig;
    desc_o.exp_neg   = exp_neg;
    desc_o.sign_char = sign_char;
    desc_o.upper     = upper_case_i;
    desc_o.pad_len   = (padding > RunCap) ? RunCap : padding;
    desc_o.zero_len  = (zeroes > RunCap) ? RunCap : zeroes;
    desc_o.total     = (width_ext > total) ? width_ext : total;
  end

endmodule

FILE: hdl/fdht_emit.sv
// ----------------------------------------------------------------------------
// Hex float text formatter: run sequencer
// Holds one decoded value and sends its runs, one per cycle while the output
// is not stalled, through an output register.
// ----------------------------------------------------------------------------
module fdht_emit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          desc_valid_i,
  output logic                          desc_ready_o,
  input  logic [fdht_pkg::NumSlots-1:0] mask_i,
  input  fdht_pkg::fdht_desc_t          desc_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    out_char_o,
  output logic [15:0]                   run_length_o,
  output logic                          last_run_o,
  output logic [16:0]                   total_chars_o
);
  import fdht_pkg::*;

  logic [NumSlots-1:0] mask_q, mask_d;
  logic [NumSlots-1:0] rest_mask;
  fdht_desc_t          desc_q;
  slot_t               slot;
  logic                busy;
  logic                last;
  logic                emit;
  logic                load;
  logic [3:0]          nib_pos;
  logic [1:0]          exp_pos;
  logic [7:0]          run_char;
  logic [15:0]         run_len;

  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_char_q;
  logic [15:0] run_len_q;
  logic        last_q;
  logic [16:0] total_q;

  // Next run is the lowest slot still marked.
  always_comb begin
    slot = SlotPadLead;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        slot = slot_t'(i);
      end
    end
    rest_mask = mask_q & (mask_q - {{(NumSlots-1){1'b0}}, 1'b1});
    busy      = (mask_q != '0);
    last      = (rest_mask == '0);
  end

  // Handshake: a new value loads as the previous one sends its final run.
  always_comb begin
    emit         = busy && (!out_valid_q || !out_stall_i);
    desc_ready_o = !busy || (emit && last);
    load         = desc_valid_i && desc_ready_o;
    if (load) begin
      mask_d = mask_i;
    end else if (emit) begin
      mask_d = rest_mask;
    end else begin
      mask_d = mask_q;
    end
  end

  // Character and repeat count of the current slot.
  always_comb begin
    nib_pos  = 4'(SlotFracLast - slot);
    exp_pos  = 2'(slot - SlotExpDig0);
    run_char = ChZero;
    run_len  = 16'd1;
    unique case (slot) inside
      SlotPadLead, SlotPadTrail: begin
        run_char = ChSpace;
        run_len  = desc_q.pad_len;
      end
      SlotSign: run_char = desc_q.sign_char;
      SlotPre0, SlotBody0: run_char = ChZero;
      SlotZeroPad: begin
        run_char = ChZero;
        run_len  = desc_q.pad_len;
      end
      SlotPreX, SlotBodyX: run_char = desc_q.upper ? ChUpX : ChLowX;
      SlotLead: run_char = hex_char(desc_q.lead, desc_q.upper);
      SlotPoint: run_char = ChPoint;
      [SlotFrac0:SlotFracLast]: begin
        run_char = hex_char(desc_q.frac[{nib_pos, 2'b00} +: 4], desc_q.upper);
      end
      SlotZeroRun: begin
        run_char = ChZero;
        run_len  = desc_q.zero_len;
      end
      SlotExpMark: run_char = desc_q.upper ? ChUpP : ChLowP;
      SlotExpSign: run_char = desc_q.exp_neg ? ChMinus : ChPlus;
      [SlotExpDig0:SlotExpDigLast]: begin
        run_char = ChZero + {4'd0, desc_q.exp_dig[exp_pos]};
      end
      default: begin
        run_char = ChZero;
        run_len  = 16'd1;
      end
    endcase
  end

  // Output register valid.
  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Value and output word payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      desc_q <= desc_i;
    end
    if (emit) begin
      out_char_q <= run_char;
      run_len_q  <= run_len;
      last_q     <= last;
      total_q    <= last ? desc_q.total : 17'd0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_char_o    = out_char_q;
  assign run_length_o  = run_len_q;
  assign last_run_o    = last_q;
  assign total_chars_o = total_q;

endmodule

FILE: sim/format_double_hex_text_tb.sv
// ----------------------------------------------------------------------------
// Hex float text formatter testbench
// Feeds binary64 values with random format settings into the formatter, under
// every rounding setting, and checks each character run it sends back against
// runs worked out here from the same value and settings.
// ----------------------------------------------------------------------------
module format_double_hex_text_tb;
  import fdht_pkg::*;

  localparam int unsigned CycleLimit  = 1_500_000;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned PhaseItems  = 34;
  localparam int unsigned SettleDelay = 6;
  localparam int unsigned DrainDelay  = 20;
  localparam int unsigned MaxRunLen   = 65535;

  // One value and its format settings, as offered on the input channel.
  typedef struct {
    logic [63:0]        value_bits;
    logic [15:0]        field_width;
    logic signed [16:0] precision;
    logic               left_justify;
    logic               zero_pad;
    logic               alternate_form;
    logic [1:0]         sign_style;
    logic               upper_case;
  } fmt_req_t;

  // One character run, as seen on the output channel.
  typedef struct packed {
    logic [7:0]  ch;
    logic [15:0] len;
    logic        last;
    logic [16:0] total;
  } run_t;

  // Register settings for one phase of the run.
  typedef struct {
    bit          legacy;
    bit          std_round;
    round_mode_e mode;
  } round_cfg_t;

  // Expected character runs of every accepted value, oldest first, and the
  // register settings they were worked out under.
  class run_scoreboard;
    run_t        expected_runs[$];
    bit          legacy    = 1'b0;
    bit          std_round = 1'b0;
    round_mode_e rnd_mode  = RndNearestEven;
    int unsigned fails     = 0;

    function void set_config(bit leg, bit std, round_mode_e mode);
      legacy    = leg;
      std_round = std;
      rnd_mode  = mode;
    endfunction

    function int unsigned pending();
      return expected_runs.size();
    endfunction

    function logic [7:0] digit_char(logic [3:0] d, bit upper);
      if (d < 4'd10) begin
        return ChZero + {4'd0, d};
      end
      return (upper ? ChUpA : ChLowA) + {4'd0, d} - 8'd10;
    endfunction

    // Empty stretches produce no run at all.
    function void add_run(logic [7:0] c, int unsigned n);
      run_t w;
      if (n == 0) begin
        return;
      end
      if (n > MaxRunLen) begin
        n = MaxRunLen;
      end
      w = '{ch: c, len: 16'(n), last: 1'b0, total: 17'd0};
      expected_runs.push_back(w);
    endfunction

    // Spell out one value as runs and queue them.
    function void note_value(fmt_req_t r);
      logic [63:0] mant, rem, guard, rr, half;
      logic [10:0] bexp;
      logic [3:0]  edig[4];
      logic [7:0]  sign_ch;
      int          expo, nd, k;
      int unsigned prec, kept, zeros, total, padding, mag, shift;
      int unsigned head_len, core_len, tail_len, field;
      bit          neg, has_sign, up, point;

      neg      = r.value_bits[63];
      has_sign = 1'b1;
      if (neg) begin
        sign_ch = ChMinus;
      end else if (r.sign_style == SignPlus) begin
        sign_ch = ChPlus;
      end else if (r.sign_style == SignSpace) begin
        sign_ch = ChSpace;
      end else begin
        has_sign = 1'b0;
        sign_ch  = ChSpace;
      end

      // Unpack the exponent; subnormals sit at -1022, zero prints +0.
      bexp = r.value_bits[62:52];
      mant = {12'd0, r.value_bits[51:0]};
      if (bexp != 0) begin
        expo = int'(bexp) - 1023;
      end else if (mant != 0) begin
        expo = -1022;
      end else begin
        expo = 0;
      end
      if (bexp != 0) begin
        mant[52] = 1'b1;
      end

      // A negative precision selects the default.
      if (r.precision[16]) begin
        prec = legacy ? 6 : MaxFracDigits;
      end else begin
        prec = r.precision[15:0];
      end
      if (legacy && prec > 512) begin
        prec = 512;
      end
      kept = (prec < MaxFracDigits) ? prec : MaxFracDigits;

      // Drop the unkept nibbles and round what is left.
      if (kept < MaxFracDigits) begin
        shift = 52 - 4 * kept;
        rem   = mant & ((64'd1 << shift) - 64'd1);
        guard = rem >> (shift - 4);
        half  = 64'd1 << (shift - 1);
        mant  = mant >> shift;
        rr    = (std_round && rnd_mode != RndNearestEven) ? (guard << (shift - 4)) : rem;
        if (legacy) begin
          up = guard > 64'd8;
        end else if (rr == 0) begin
          up = 1'b0;
        end else if (!std_round) begin
          up = rr >= half;
        end else begin
          case (rnd_mode)
            RndDown: up = neg;
            RndUp:   up = !neg;
            RndZero: up = 1'b0;
            default: up = (rr > half) || (rr == half && mant[0]);
          endcase
        end
        if (up) begin
          mant = mant + 64'd1;
        end
      end

      point = (prec != 0) || r.alternate_form;
      zeros = prec - kept;

      // Decimal exponent digits, least significant first.
      mag = (expo < 0) ? -expo : expo;
      nd  = 0;
      do begin
        edig[nd] = 4'(mag % 10);
        mag      = mag / 10;
        nd++;
      end while (mag != 0 && nd < 4);

      head_len = (has_sign ? 1 : 0) + (legacy ? 0 : 2);
      core_len = (legacy ? 2 : 0) + 1 + (point ? 1 : 0) + kept;
      tail_len = 2 + nd;
      total    = head_len + core_len + zeros + tail_len;
      padding  = (r.field_width > total) ? r.field_width - total : 0;
      field    = (r.field_width > total) ? r.field_width : total;

      if (!r.left_justify && !r.zero_pad) begin
        add_run(ChSpace, padding);
      end
      if (has_sign) begin
        add_run(sign_ch, 1);
      end
      if (!legacy) begin
        add_run(ChZero, 1);
        add_run(r.upper_case ? ChUpX : ChLowX, 1);
      end
      if (!r.left_justify && r.zero_pad) begin
        add_run(ChZero, padding);
      end
      if (legacy) begin
        add_run(ChZero, 1);
        add_run(r.upper_case ? ChUpX : ChLowX, 1);
      end
      add_run(digit_char(4'(mant >> (4 * kept)), r.upper_case), 1);
      if (point) begin
        add_run(ChPoint, 1);
      end
      for (k = int'(kept) - 1; k >= 0; k--) begin
        add_run(digit_char(4'(mant >> (4 * k)), r.upper_case), 1);
      end
      add_run(ChZero, zeros);
      add_run(r.upper_case ? ChUpP : ChLowP, 1);
      add_run((expo < 0) ? ChMinus : ChPlus, 1);
      for (k = nd - 1; k >= 0; k--) begin
        add_run(ChZero + {4'd0, edig[k]}, 1);
      end
      if (r.left_justify) begin
        add_run(ChSpace, padding);
      end

      // The final run carries the field length.
      expected_runs[expected_runs.size() - 1].last  = 1'b1;
      expected_runs[expected_runs.size() - 1].total = 17'(field);
    endfunction

    // Compare one output word with the oldest expected run.
    function void check_run(run_t got);
      run_t want;
      if (expected_runs.size() == 0) begin
        $error("unexpected word: char %h, length %0d", got.ch, got.len);
        fails++;
        return;
      end
      want = expected_runs.pop_front();
      if (got.ch !== want.ch) begin
        $error("out_char: expected %h, got %h", want.ch, got.ch);
        fails++;
      end
      if (got.len !== want.len) begin
        $error("run_length: expected %0d, got %0d", want.len, got.len);
        fails++;
      end
      if (got.last !== want.last) begin
        $error("last_run: expected %b, got %b", want.last, got.last);
        fails++;
      end
      if (got.total !== want.total) begin
        $error("total_chars: expected %0d, got %0d", want.total, got.total);
        fails++;
      end
    endfunction
  endclass

  logic               clk_i            = 1'b0;
  logic               rst_ni           = 1'b0;
  logic               cfg_valid_i      = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i      = '0;
  logic [1:0]         cfg_data_i       = '0;
  logic               in_valid_i       = 1'b0;
  logic [63:0]        value_bits_i     = '0;
  logic [15:0]        field_width_i    = '0;
  logic signed [16:0] precision_i      = '0;
  logic               left_justify_i   = 1'b0;
  logic               zero_pad_i       = 1'b0;
  logic               alternate_form_i = 1'b0;
  logic [1:0]         sign_style_i     = '0;
  logic               upper_case_i     = 1'b0;
  logic               out_stall_i      = 1'b0;
  logic               cfg_ready_o;
  logic               in_stall_o;
  logic               out_valid_o;
  logic [7:0]         out_char_o;
  logic [15:0]        run_length_o;
  logic               last_run_o;
  logic [16:0]        total_chars_o;

  run_scoreboard sb = new();
  int unsigned   cycles       = 0;
  bit            steady       = 1'b0;
  bit            hold_request = 1'b0;

  round_cfg_t phase_cfg[8] = '{
    '{1'b0, 1'b0, RndNearestEven},
    '{1'b0, 1'b1, RndNearestEven},
    '{1'b0, 1'b1, RndDown},
    '{1'b0, 1'b1, RndUp},
    '{1'b0, 1'b1, RndZero},
    '{1'b1, 1'b0, RndNearestEven},
    '{1'b1, 1'b1, RndZero},
    '{1'b0, 1'b0, RndZero}
  };

  format_double_hex_text uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .value_bits_i    (value_bits_i),
    .field_width_i   (field_width_i),
    .precision_i     (precision_i),
    .left_justify_i  (left_justify_i),
    .zero_pad_i      (zero_pad_i),
    .alternate_form_i(alternate_form_i),
    .sign_style_i    (sign_style_i),
    .upper_case_i    (upper_case_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_char_o      (out_char_o),
    .run_length_o    (run_length_o),
    .last_run_o      (last_run_o),
    .total_chars_o   (total_chars_o)
  );

  always #5 clk_i = ~clk_i;

  // Give up if the run hangs.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Check every run word the formatter hands over.
  always @(posedge clk_i) begin : run_monitor
    run_t seen;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen = '{ch: out_char_o, len: run_length_o, last: last_run_o, total: total_chars_o};
      sb.check_run(seen);
    end
  end

  // Output stall pattern: clean stretches, short stalls, a few long ones, and
  // one long hold-off on request.
  initial begin : out_stall_gen
    int unsigned sel, burst;
    forever begin
      if (hold_request) begin
        hold_request <= 1'b0;
        out_stall_i  <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 15) begin
          out_stall_i <= 1'b0;
          burst = $urandom_range(20, 80);
        end else if (sel < 55) begin
          out_stall_i <= 1'b0;
          burst = $urandom_range(1, 4);
        end else if (sel < 93) begin
          out_stall_i <= 1'b1;
          burst = $urandom_range(1, 3);
        end else begin
          out_stall_i <= 1'b1;
          burst = $urandom_range(8, 30);
        end
        repeat (burst) @(posedge clk_i);
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) return 0;
    if (sel < 85) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic fmt_req_t make_req(logic [63:0] bits, int unsigned width, int prec,
                                        bit left, bit zpad, bit alt, logic [1:0] sstyle,
                                        bit upper);
    fmt_req_t r;
    r.value_bits     = bits;
    r.field_width    = 16'(width);
    r.precision      = 17'(prec);
    r.left_justify   = left;
    r.zero_pad       = zpad;
    r.alternate_form = alt;
    r.sign_style     = sstyle;
    r.upper_case     = upper;
    return r;
  endfunction

  // Random value and settings, biased toward rounding ties, carries and
  // the special exponents.
  function automatic fmt_req_t pick_request();
    fmt_req_t    r;
    int unsigned sel, pos, shift;
    logic [63:0] mask;
    r.value_bits = {$urandom, $urandom};
    sel = $urandom_range(0, 99);
    if (sel < 10) begin
      r.precision = $urandom_range(0, 1) ? -17'sd1 : {1'b1, 16'($urandom)};
    end else if (sel < 70) begin
      r.precision = 17'($urandom_range(0, 13));
    end else if (sel < 85) begin
      r.precision = 17'($urandom_range(14, 40));
    end else if (sel < 95) begin
      r.precision = 17'($urandom_range(500, 600));
    end else begin
      r.precision = {1'b0, 16'($urandom)};
    end
    case ($urandom_range(0, 9))
      0: r.value_bits[62:52] = '0;
      1: r.value_bits[62:52] = '1;
      2: r.value_bits[62:0] = '0;
      3, 4: begin
        // Place a tie, or a near tie, right below the last kept digit.
        if (r.precision >= 0 && r.precision < 13) begin
          pos = r.precision[15:0];
        end else begin
          pos = $urandom_range(0, 12);
        end
        shift = 52 - 4 * pos;
        mask  = (64'd1 << shift) - 64'd1;
        r.value_bits = (r.value_bits & ~mask) | (64'd1 << (shift - 1));
        case ($urandom_range(0, 3))
          1: r.value_bits = r.value_bits | 64'd1;
          2: r.value_bits = r.value_bits | (64'd1 << (shift - 4));
          3: r.value_bits = (r.value_bits & ~mask) | (mask >> 1);
          default: ;
        endcase
      end
      5: r.value_bits[51:0] = '1;
      default: ;
    endcase
    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      r.field_width = 16'($urandom_range(0, 50));
    end else if (sel < 85) begin
      r.field_width = 16'($urandom_range(0, 200));
    end else begin
      r.field_width = 16'($urandom);
    end
    r.left_justify   = $urandom_range(0, 1);
    r.zero_pad       = $urandom_range(0, 1);
    r.alternate_form = $urandom_range(0, 1);
    r.sign_style     = 2'($urandom_range(0, 3));
    r.upper_case     = $urandom_range(0, 1);
    return r;
  endfunction

  // Offer one value, hold it until taken, then idle for a random gap, which may be zero.
  task automatic send_value(input fmt_req_t r);
    int unsigned gap;
    in_valid_i       <= 1'b1;
    value_bits_i     <= r.value_bits;
    field_width_i    <= r.field_width;
    precision_i      <= r.precision;
    left_justify_i   <= r.left_justify;
    zero_pad_i       <= r.zero_pad;
    alternate_form_i <= r.alternate_form;
    sign_style_i     <= r.sign_style;
    upper_case_i     <= r.upper_case;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_value(r);
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop offering and wait until every expected run has come out.
  task automatic wait_idle(input int unsigned settle);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // Offer one register word and hold it until taken; the caller drops valid.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic apply_config(input round_cfg_t c);
    write_reg(CfgIdxLegacy, {1'b0, c.legacy});
    write_reg(CfgIdxStdRound, {1'b0, c.std_round});
    write_reg(CfgIdxRoundMode, 2'(c.mode));
    cfg_valid_i <= 1'b0;
    sb.set_config(c.legacy, c.std_round, c.mode);
  endtask

  initial begin : stimulus
    int unsigned ph, n;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed values under the reset settings.
    send_value(make_req(64'h0000000000000000, 0, -1, 0, 0, 0, 2'd0, 0));
    send_value(make_req(64'h8000000000000000, 0, -1, 0, 0, 0, SignPlus, 0));
    send_value(make_req(64'h3ff0000000000000, 0, 0, 0, 0, 0, 2'd0, 0));
    send_value(make_req(64'h3ff0000000000000, 0, 0, 0, 0, 1, 2'd0, 1));
    send_value(make_req(64'h0000000000000001, 0, -1, 0, 0, 0, 2'd0, 0));
    send_value(make_req(64'h000fffffffffffff, 0, 2, 0, 0, 0, 2'd0, 0));
    send_value(make_req(64'h7fefffffffffffff, 0, 1, 0, 0, 0, SignSpace, 0));
    send_value(make_req(64'h7ff0000000000000, 0, -1, 0, 0, 0, 2'd0, 0));
    send_value(make_req(64'hffffffffffffffff, 0, 13, 0, 0, 0, 2'd0, 1));
    send_value(make_req(64'h3ff8000000000000, 0, 0, 0, 0, 0, 2'd0, 0));
    send_value(make_req(64'h3ff0800000000000, 0, 1, 0, 0, 0, 2'd0, 0));
    send_value(make_req(64'h4000000000000000, 65535, 0, 0, 0, 0, 2'd0, 0));
    send_value(make_req(64'h4000000000000000, 65535, 0, 0, 1, 0, 2'd0, 0));
    send_value(make_req(64'h4000000000000000, 65535, 0, 1, 1, 0, 2'd0, 0));
    send_value(make_req(64'hc000000000000000, 30, 3, 0, 1, 0, SignPlus, 0));
    send_value(make_req(64'h3ff0000000000000, 0, 65535, 0, 0, 0, 2'd0, 0));
    send_value(make_req(64'h3ff0000000000000, 0, -65536, 0, 0, 0, 2'd0, 0));
    send_value(make_req(64'h0010000000000000, 25, 4, 1, 0, 0, 2'd3, 0));
    send_value(make_req(64'h3fb999999999999a, 20, 5, 0, 1, 1, SignPlus, 1));
    send_value(make_req(64'h0000000000000000, 0, 0, 0, 0, 0, 2'd0, 0));

    // Random values, one phase per register setting.
    for (ph = 0; ph < 8; ph++) begin
      wait_idle(SettleDelay);
      apply_config(phase_cfg[ph]);
      if (ph == 2) begin
        hold_request <= 1'b1;
      end
      for (n = 0; n < PhaseItems; n++) begin
        if (n % 16 == 0) begin
          steady = ($urandom_range(0, 3) == 0);
        end
        send_value(pick_request());
      end
      steady = 1'b0;
    end

    wait_idle(DrainDelay);
    if (sb.fails == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/fdht_pkg.sv
hdl/fdht_prep.sv
hdl/fdht_emit.sv
hdl/format_double_hex_text.sv
sim/format_double_hex_text_tb.sv
